// File: rtl/tps_pkg.sv
package tps_pkg;

  // default sizes
  localparam int NODE_COUNT_DEF = 128;
  localparam int MAX_LIST_DEF   = 32;

  // field widths
  localparam int VAL_W = 7;
  localparam int POS_W = 5;
  localparam int ERR_W = 2;

  // input actions
  localparam logic ACT_RULE = 1'b0;
  localparam logic ACT_NODE = 1'b1;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CYCLE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DUP   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVF   = 2'd3;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] rule_before;
    logic [VAL_W-1:0] rule_after;
    logic [VAL_W-1:0] node_value;
    logic             node_last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_node;
    logic [POS_W-1:0] position;
    logic             run_last;
    logic             was_ordered;
    logic [ERR_W-1:0] error;
  } out_item_t;

  // a node value has rules only if it lies inside the matrix
  function automatic logic node_ok(input logic [VAL_W-1:0] v, input int count);
    node_ok = (int'(v) < count);
  endfunction

endpackage

// File: rtl/tps_ram.sv
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tps_lanes.sv
module tps_lanes #(
  parameter int NODE_COUNT = tps_pkg::NODE_COUNT_DEF,
  parameter int MAX_LIST   = tps_pkg::MAX_LIST_DEF
) (
  input  logic [NODE_COUNT-1:0]      row,
  input  logic [tps_pkg::VAL_W-1:0]  list [MAX_LIST],
  input  logic [tps_pkg::VAL_W-1:0]  src,
  output logic [MAX_LIST-1:0]        succ,
  output logic [MAX_LIST-1:0]        eq
);

  localparam int NW = $clog2(NODE_COUNT);

  logic src_ok;

  assign src_ok = tps_pkg::node_ok(src, NODE_COUNT);

  // per list slot: is it a successor of the row's node, and is it the same value
  always_comb begin
    for (int i = 0; i < MAX_LIST; i++) begin
      succ[i] = src_ok && tps_pkg::node_ok(list[i], NODE_COUNT) && row[NW'(list[i])];
      eq[i]   = (list[i] == src);
    end
  end

endmodule

// File: rtl/precedence_topological_sorter_unit.sv
// Precedence sorter. Rules (before, after) go into a NODE_COUNT x NODE_COUNT bit
// matrix held as one row per "before" node; after reset a clearing pass writes
// NODE_COUNT rows, one a cycle, and no transfer is accepted meanwhile. A rule
// takes a row read, then a row write. A list node takes a row read, then a
// check against every held node at once. The last node starts the sort: the
// in-degrees are built with one row read per node, then scan passes run over
// the list, each emitted node adding a row read, at most n passes, then n
// result transfers (one on error). All sorting time is set by the single
// matrix read port, one row per cycle, read through a registered output.
module precedence_topological_sorter_unit #(
  parameter int NODE_COUNT = tps_pkg::NODE_COUNT_DEF,
  parameter int MAX_LIST   = tps_pkg::MAX_LIST_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tps_pkg::out_item_t out_data
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int IW = $clog2(MAX_LIST);
  localparam int LW = $clog2(MAX_LIST + 1);
  localparam int VW = tps_pkg::VAL_W;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RULE_WR = 4'd2;
  localparam logic [3:0] ST_LOAD    = 4'd3;
  localparam logic [3:0] ST_DEG_RD  = 4'd4;
  localparam logic [3:0] ST_DEG_ACC = 4'd5;
  localparam logic [3:0] ST_SCAN    = 4'd6;
  localparam logic [3:0] ST_DEC     = 4'd7;
  localparam logic [3:0] ST_OUT     = 4'd8;
  localparam logic [3:0] ST_ERR_OUT = 4'd9;

  logic [3:0]               state_r, state_nxt;
  logic [NW-1:0]            clr_r, clr_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic                     order_ok_r, order_ok_nxt;
  logic [tps_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [VW-1:0]            cur_val_r, cur_val_nxt;
  logic [VW-1:0]            cur_b_r, cur_b_nxt;
  logic                     cur_last_r, cur_last_nxt;
  logic                     rule_ok_r, rule_ok_nxt;
  logic [VW-1:0]            list_r [MAX_LIST];
  logic [VW-1:0]            list_nxt [MAX_LIST];
  logic [LW-1:0]            indeg_r [MAX_LIST];
  logic [LW-1:0]            indeg_nxt [MAX_LIST];
  logic [VW-1:0]            ord_r [MAX_LIST];
  logic [VW-1:0]            ord_nxt [MAX_LIST];
  logic [MAX_LIST-1:0]      emit_r, emit_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [LW-1:0]            done_r, done_nxt;
  logic                     prog_r, prog_nxt;

  logic                     ram_we;
  logic [NW-1:0]            ram_waddr;
  logic [NODE_COUNT-1:0]    ram_wdata;
  logic [NW-1:0]            ram_raddr;
  logic [NODE_COUNT-1:0]    ram_rdata;
  logic [MAX_LIST-1:0]      succ, eq, len_mask;
  logic                     last_idx;
  logic                     in_xfer, out_xfer;

  // rule matrix, one row per "before" node
  tps_ram #(
    .WIDTH (NODE_COUNT),
    .DEPTH (NODE_COUNT)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // successor and equality lanes over the held list
  tps_lanes #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_LIST   (MAX_LIST)
  ) u_lanes (
    .row  (ram_rdata),
    .list (list_r),
    .src  (cur_val_r),
    .succ (succ),
    .eq   (eq)
  );

  always_comb begin
    for (int i = 0; i < MAX_LIST; i++) begin
      len_mask[i] = (LW'(i) < len_r);
    end
  end

  assign last_idx = ((LW'(idx_r) + LW'(1)) == len_r);
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (state_r == ST_OUT) || (state_r == ST_ERR_OUT);
  assign out_xfer = out_valid && out_ready;

  // result payload
  always_comb begin
    if (state_r == ST_OUT) begin
      out_data.sorted_node = ord_r[idx_r];
      out_data.position    = tps_pkg::POS_W'(idx_r);
      out_data.run_last    = last_idx;
      out_data.was_ordered = order_ok_r;
      out_data.error       = tps_pkg::ERR_NONE;
    end else begin
      out_data.sorted_node = '0;
      out_data.position    = '0;
      out_data.run_last    = 1'b1;
      out_data.was_ordered = 1'b0;
      out_data.error       = err_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    len_nxt      = len_r;
    order_ok_nxt = order_ok_r;
    err_nxt      = err_r;
    cur_val_nxt  = cur_val_r;
    cur_b_nxt    = cur_b_r;
    cur_last_nxt = cur_last_r;
    rule_ok_nxt  = rule_ok_r;
    list_nxt     = list_r;
    indeg_nxt    = indeg_r;
    ord_nxt      = ord_r;
    emit_nxt     = emit_r;
    idx_nxt      = idx_r;
    done_nxt     = done_r;
    prog_nxt     = prog_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + NW'(1);
        if (clr_r == NW'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == tps_pkg::ACT_RULE) begin
            ram_raddr   = NW'(in_data.rule_before);
            cur_b_nxt   = in_data.rule_before;
            cur_val_nxt = in_data.rule_after;
            rule_ok_nxt = tps_pkg::node_ok(in_data.rule_before, NODE_COUNT) &&
                          tps_pkg::node_ok(in_data.rule_after, NODE_COUNT);
            state_nxt   = ST_RULE_WR;
          end else begin
            ram_raddr    = NW'(in_data.node_value);
            cur_val_nxt  = in_data.node_value;
            cur_last_nxt = in_data.node_last;
            state_nxt    = ST_LOAD;
          end
        end
      end
      ST_RULE_WR: begin
        ram_we    = rule_ok_r;
        ram_waddr = NW'(cur_b_r);
        ram_wdata = ram_rdata | ({{(NODE_COUNT-1){1'b0}}, 1'b1} << NW'(cur_val_r));
        state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        if (len_r == LW'(MAX_LIST)) begin
          if (err_r == tps_pkg::ERR_NONE) begin
            err_nxt = tps_pkg::ERR_OVF;
          end
        end else begin
          if (((eq & len_mask) != '0) && (err_r == tps_pkg::ERR_NONE)) begin
            err_nxt = tps_pkg::ERR_DUP;
          end
          if ((succ & len_mask) != '0) begin
            order_ok_nxt = 1'b0;
          end
          list_nxt[IW'(len_r)] = cur_val_r;
          len_nxt = len_r + LW'(1);
        end
        if (!cur_last_r) begin
          state_nxt = ST_IDLE;
        end else if (err_nxt != tps_pkg::ERR_NONE) begin
          state_nxt = ST_ERR_OUT;
        end else begin
          idx_nxt = '0;
          for (int i = 0; i < MAX_LIST; i++) begin
            indeg_nxt[i] = '0;
          end
          state_nxt = ST_DEG_RD;
        end
      end
      ST_DEG_RD: begin
        ram_raddr   = NW'(list_r[idx_r]);
        cur_val_nxt = list_r[idx_r];
        state_nxt   = ST_DEG_ACC;
      end
      ST_DEG_ACC: begin
        for (int i = 0; i < MAX_LIST; i++) begin
          if (len_mask[i] && succ[i]) begin
            indeg_nxt[i] = indeg_r[i] + LW'(1);
          end
        end
        if (last_idx) begin
          idx_nxt   = '0;
          done_nxt  = '0;
          prog_nxt  = 1'b0;
          emit_nxt  = '0;
          state_nxt = ST_SCAN;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ST_DEG_RD;
        end
      end
      ST_SCAN, ST_DEC: begin
        if ((state_r == ST_SCAN) && (indeg_r[idx_r] == '0) && !emit_r[idx_r]) begin
          // emit this node, then take its row to release successors
          emit_nxt[idx_r]     = 1'b1;
          ord_nxt[IW'(done_r)] = list_r[idx_r];
          done_nxt            = done_r + LW'(1);
          prog_nxt            = 1'b1;
          ram_raddr           = NW'(list_r[idx_r]);
          cur_val_nxt         = list_r[idx_r];
          state_nxt           = ST_DEC;
        end else begin
          if (state_r == ST_DEC) begin
            for (int i = 0; i < MAX_LIST; i++) begin
              if (len_mask[i] && succ[i] && (indeg_r[i] != '0)) begin
                indeg_nxt[i] = indeg_r[i] - LW'(1);
              end
            end
          end
          // advance the scan, closing the pass at the list end
          if (!last_idx) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = ST_SCAN;
          end else if (done_r == len_r) begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end else if (!prog_r) begin
            err_nxt   = tps_pkg::ERR_CYCLE;
            state_nxt = ST_ERR_OUT;
          end else begin
            idx_nxt   = '0;
            prog_nxt  = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (last_idx) begin
            len_nxt      = '0;
            order_ok_nxt = 1'b1;
            err_nxt      = tps_pkg::ERR_NONE;
            emit_nxt     = '0;
            state_nxt    = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      ST_ERR_OUT: begin
        if (out_xfer) begin
          len_nxt      = '0;
          order_ok_nxt = 1'b1;
          err_nxt      = tps_pkg::ERR_NONE;
          emit_nxt     = '0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      len_r      <= '0;
      order_ok_r <= 1'b1;
      err_r      <= tps_pkg::ERR_NONE;
      emit_r     <= '0;
      idx_r      <= '0;
      done_r     <= '0;
      prog_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      len_r      <= len_nxt;
      order_ok_r <= order_ok_nxt;
      err_r      <= err_nxt;
      emit_r     <= emit_nxt;
      idx_r      <= idx_nxt;
      done_r     <= done_nxt;
      prog_r     <= prog_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_val_r  <= cur_val_nxt;
    cur_b_r    <= cur_b_nxt;
    cur_last_r <= cur_last_nxt;
    rule_ok_r  <= rule_ok_nxt;
    list_r     <= list_nxt;
    indeg_r    <= indeg_nxt;
    ord_r      <= ord_nxt;
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_LIST))
    else $error("list length beyond capacity");

  a_out_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (done_r == len_r))
    else $error("sorted output started before every node was emitted");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) || (state_r == ST_DEC)) |->
      ($countones(emit_r) == int'(done_r)))
    else $error("emitted marks disagree with emitted count");

endmodule
